// File: hdl/rph_pkg.sv
// Shared types, widths and codes of the ranged pixel histogram.
`timescale 1ns / 1ps

package rph_pkg;

  // Store and datapath sizes
  localparam int BINS    = 256;
  localparam int PIX_W   = 16;
  localparam int CNT_W   = 32;
  localparam int BC_W    = 9;
  localparam int CFG_IW  = 3;
  localparam int BIN_AW  = $clog2(BINS);
  localparam int PROD_W  = BIN_AW + PIX_W;
  localparam int STEP_W  = $clog2(BIN_AW);

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_READ_BIN    = 2'd1,
    OP_READ_TOTALS = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_RANGE_LOW     = 3'd0,
    CFG_RANGE_HIGH    = 3'd1,
    CFG_BIN_COUNT     = 3'd2,
    CFG_NODATA_VALUE  = 3'd3,
    CFG_NODATA_ENABLE = 3'd4
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_READ,
    S_WRITE
  } state_e;

  // Bin memory write request
  typedef struct packed {
    logic              en;
    logic [BIN_AW-1:0] addr;
    logic [CNT_W-1:0]  data;
  } ram_wr_t;

  // Bin divider start request
  typedef struct packed {
    logic              start;
    logic [BIN_AW-1:0] em1;
    logic [PIX_W-1:0]  off;
    logic [PIX_W-1:0]  span;
  } div_req_t;

  // Saturating increment of a counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == '1) ? c : c + CNT_W'(1);
    return r;
  endfunction

endpackage

// File: hdl/rph_bin_ram.sv
// Bin count memory: one write port, one registered read port.
`timescale 1ns / 1ps

module rph_bin_ram (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [rph_pkg::BIN_AW-1:0]   rd_addr_i,
  output logic [rph_pkg::CNT_W-1:0]    rd_data_o,
  input  rph_pkg::ram_wr_t             wr_i
);

  logic [rph_pkg::CNT_W-1:0] mem [rph_pkg::BINS];
  logic [rph_pkg::CNT_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, data registered and valid in the cycle after the request
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/rph_bin_div.sv
// Bin index unit: (E-1)*offset / span by restoring division, one quotient bit a cycle.
`timescale 1ns / 1ps

module rph_bin_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rph_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [rph_pkg::BIN_AW-1:0]  quot_o
);

  logic [rph_pkg::PROD_W-1:0] prod;
  logic [rph_pkg::PIX_W-1:0]  rem_q, rem_d;
  logic [rph_pkg::BIN_AW-1:0] low_q;
  logic [rph_pkg::BIN_AW-1:0] q_q;
  logic [rph_pkg::PIX_W-1:0]  span_q;
  logic [rph_pkg::STEP_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [rph_pkg::PIX_W:0]    shifted;
  logic [rph_pkg::PIX_W:0]    diff;
  logic                       ge;
  logic                       last;

  // Product of bin scale and offset; the quotient is known to fit BIN_AW bits
  assign prod = rph_pkg::PROD_W'(req_i.em1) * rph_pkg::PROD_W'(req_i.off);

  // One restoring step
  always_comb begin
    shifted = {rem_q, low_q[rph_pkg::BIN_AW-1]};
    ge      = shifted >= {1'b0, span_q};
    diff    = shifted - {1'b0, span_q};
    rem_d   = ge ? diff[rph_pkg::PIX_W-1:0] : shifted[rph_pkg::PIX_W-1:0];
    last    = cnt_q == rph_pkg::STEP_W'(rph_pkg::BIN_AW - 1);
  end

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + rph_pkg::STEP_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load the product, then shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= prod[rph_pkg::PROD_W-1:rph_pkg::BIN_AW];
      low_q  <= prod[rph_pkg::BIN_AW-1:0];
      span_q <= req_i.span;
      q_q    <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[rph_pkg::BIN_AW-2:0], 1'b0};
      q_q   <= {q_q[rph_pkg::BIN_AW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// File: hdl/ranged_pixel_histogram.sv
// Top level of the ranged pixel histogram: sequencer, totals, config and output word.
`timescale 1ns / 1ps

// Histogram of signed 16-bit pixels over 256 bins of 32-bit saturating counts. One word is
// handled at a time. A sample outside the range or equal to the enabled no-data value is
// accepted and checked; a binned sample with low < high goes through accept, check with the
// product loaded, the divider steps, quotient pick-up, bin memory read and write back, and
// skips the divider when the range is a single value. A bin read goes through accept, check,
// read and write back and a totals read through accept and check, both also waiting while
// the output word is not taken; the result word sits in an output register, so the next
// input word is taken while it waits. The iterative bin divider and the one-entry-at-a-time
// read-modify-write of the bin memory set this pacing. After reset the bin memory is cleared
// in a pass over all 256 entries during which no input word is taken; configuration writes
// are taken at all times and should be made while the block is idle.
module ranged_pixel_histogram (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rph_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [rph_pkg::PIX_W-1:0]         cfg_data_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic signed [rph_pkg::PIX_W-1:0]  pixel_i,
  input  logic [rph_pkg::BIN_AW-1:0]        bin_index_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rph_pkg::CNT_W-1:0]         bin_value_o,
  output logic [rph_pkg::CNT_W-1:0]         valid_total_o,
  output logic [rph_pkg::CNT_W-1:0]         invalid_total_o
);

  // Configuration registers
  logic signed [rph_pkg::PIX_W-1:0] range_low_q, range_high_q, nodata_value_q;
  logic [rph_pkg::BC_W-1:0]         bin_count_q;
  logic                             nodata_enable_q;

  // Sequencer and captured word
  rph_pkg::state_e                  state_q, state_d;
  rph_pkg::op_e                     op_q;
  logic signed [rph_pkg::PIX_W-1:0] pixel_q;
  logic [rph_pkg::BIN_AW-1:0]       bin_index_q;
  logic [rph_pkg::BIN_AW-1:0]       addr_q;
  logic [rph_pkg::BIN_AW-1:0]       clr_q;

  // Totals and output word
  logic [rph_pkg::CNT_W-1:0]        valid_cnt_q, invalid_cnt_q;
  logic                             out_valid_q;
  logic [rph_pkg::CNT_W-1:0]        bin_value_q, valid_total_q, invalid_total_q;

  // Datapath
  logic                             in_accept;
  logic                             slot_free;
  logic                             range_pos;
  logic                             invalid;
  logic [rph_pkg::PIX_W:0]          span_w, off_w;
  logic [rph_pkg::BIN_AW-1:0]       em1;
  logic                             div_done;
  logic [rph_pkg::BIN_AW-1:0]       div_quot;
  logic [rph_pkg::CNT_W-1:0]        rd_data;

  // FSM outputs
  logic                             stall;
  logic                             rd_en;
  logic                             inc_valid, inc_invalid;
  logic                             load_totals, load_bin;
  rph_pkg::ram_wr_t                 wr;
  rph_pkg::div_req_t                div_req;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = stall;
  assign in_accept   = in_valid_i && !stall;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q     <= '0;
      range_high_q    <= rph_pkg::PIX_W'(255);
      bin_count_q     <= '0;
      nodata_value_q  <= '0;
      nodata_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (rph_pkg::cfg_idx_e'(cfg_index_i))
        rph_pkg::CFG_RANGE_LOW:     range_low_q     <= cfg_data_i;
        rph_pkg::CFG_RANGE_HIGH:    range_high_q    <= cfg_data_i;
        rph_pkg::CFG_BIN_COUNT:     bin_count_q     <= cfg_data_i[rph_pkg::BC_W-1:0];
        rph_pkg::CFG_NODATA_VALUE:  nodata_value_q  <= cfg_data_i;
        rph_pkg::CFG_NODATA_ENABLE: nodata_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify the captured pixel and derive bin scale
  always_comb begin
    range_pos = range_high_q > range_low_q;
    invalid   = (nodata_enable_q && (pixel_q == nodata_value_q)) ||
                (pixel_q > range_high_q) || (pixel_q < range_low_q);
    span_w    = {range_high_q[rph_pkg::PIX_W-1], range_high_q} -
                {range_low_q[rph_pkg::PIX_W-1], range_low_q};
    off_w     = {pixel_q[rph_pkg::PIX_W-1], pixel_q} -
                {range_low_q[rph_pkg::PIX_W-1], range_low_q};
    if (bin_count_q != '0) begin
      if (bin_count_q >= rph_pkg::BC_W'(rph_pkg::BINS)) begin
        em1 = rph_pkg::BIN_AW'(rph_pkg::BINS - 1);
      end else begin
        em1 = rph_pkg::BIN_AW'(bin_count_q - rph_pkg::BC_W'(1));
      end
    end else if (span_w[rph_pkg::PIX_W-1:0] >= rph_pkg::PIX_W'(rph_pkg::BINS - 1)) begin
      em1 = rph_pkg::BIN_AW'(rph_pkg::BINS - 1);
    end else begin
      em1 = span_w[rph_pkg::BIN_AW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rph_pkg::S_CLEAR: begin
        if (clr_q == rph_pkg::BIN_AW'(rph_pkg::BINS - 1)) state_d = rph_pkg::S_IDLE;
      end
      rph_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rph_pkg::S_CHECK;
      end
      rph_pkg::S_CHECK: begin
        unique case (op_q)
          rph_pkg::OP_SAMPLE: begin
            if (invalid)        state_d = rph_pkg::S_IDLE;
            else if (!range_pos) state_d = rph_pkg::S_READ;
            else                state_d = rph_pkg::S_DIV;
          end
          rph_pkg::OP_READ_BIN:    state_d = rph_pkg::S_READ;
          rph_pkg::OP_READ_TOTALS: begin
            if (slot_free) state_d = rph_pkg::S_IDLE;
          end
          default: state_d = rph_pkg::S_IDLE;
        endcase
      end
      rph_pkg::S_DIV: begin
        if (div_done) state_d = rph_pkg::S_READ;
      end
      rph_pkg::S_READ: state_d = rph_pkg::S_WRITE;
      rph_pkg::S_WRITE: begin
        if (op_q == rph_pkg::OP_SAMPLE || slot_free) state_d = rph_pkg::S_IDLE;
      end
      default: state_d = rph_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    stall        = 1'b1;
    rd_en        = 1'b0;
    inc_valid    = 1'b0;
    inc_invalid  = 1'b0;
    load_totals  = 1'b0;
    load_bin     = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = addr_q;
    wr.data      = '0;
    div_req.start = 1'b0;
    div_req.em1   = em1;
    div_req.off   = off_w[rph_pkg::PIX_W-1:0];
    div_req.span  = span_w[rph_pkg::PIX_W-1:0];
    unique case (state_q)
      rph_pkg::S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_q;
      end
      rph_pkg::S_IDLE: stall = 1'b0;
      rph_pkg::S_CHECK: begin
        unique case (op_q)
          rph_pkg::OP_SAMPLE: begin
            if (invalid) begin
              inc_invalid = 1'b1;
            end else begin
              inc_valid     = 1'b1;
              div_req.start = range_pos;
            end
          end
          rph_pkg::OP_READ_TOTALS: load_totals = slot_free;
          default: ;
        endcase
      end
      rph_pkg::S_DIV: ;
      rph_pkg::S_READ: rd_en = 1'b1;
      rph_pkg::S_WRITE: begin
        if (op_q == rph_pkg::OP_SAMPLE) begin
          wr.en   = 1'b1;
          wr.data = rph_pkg::sat_inc(rd_data);
        end else if (slot_free) begin
          wr.en    = 1'b1;
          load_bin = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rph_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rph_pkg::S_CLEAR) clr_q <= clr_q + rph_pkg::BIN_AW'(1);
    end
  end

  // Capture the input word and the bin address
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q        <= rph_pkg::op_e'(operation_i);
      pixel_q     <= pixel_i;
      bin_index_q <= bin_index_i;
    end
    if (state_q == rph_pkg::S_CHECK) begin
      addr_q <= (op_q == rph_pkg::OP_READ_BIN) ? bin_index_q : '0;
    end else if (div_done) begin
      addr_q <= div_quot;
    end
  end

  // Valid and invalid totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_cnt_q   <= '0;
      invalid_cnt_q <= '0;
    end else if (load_totals) begin
      valid_cnt_q   <= '0;
      invalid_cnt_q <= '0;
    end else begin
      if (inc_valid)   valid_cnt_q   <= rph_pkg::sat_inc(valid_cnt_q);
      if (inc_invalid) invalid_cnt_q <= rph_pkg::sat_inc(invalid_cnt_q);
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_totals || load_bin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (load_totals) begin
      bin_value_q     <= '0;
      valid_total_q   <= valid_cnt_q;
      invalid_total_q <= invalid_cnt_q;
    end else if (load_bin) begin
      bin_value_q     <= rd_data;
      valid_total_q   <= '0;
      invalid_total_q <= '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bin_value_o     = bin_value_q;
  assign valid_total_o   = valid_total_q;
  assign invalid_total_o = invalid_total_q;

  rph_bin_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  rph_bin_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // A result word carries either a bin count or the totals, never both
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bin_value_o == '0) || (valid_total_o == '0 && invalid_total_o == '0))
    else $error("result word mixes bin count and totals");

  // The divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == rph_pkg::S_DIV)
    else $error("divider finished outside its wait state");

  // No input word is taken during the clearing sweep
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rph_pkg::S_CLEAR |-> in_stall_o)
    else $error("input taken during clearing sweep");

  // A bin memory read is always followed by its write back state
  a_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> state_q == rph_pkg::S_WRITE)
    else $error("bin read not followed by write back");

endmodule

// File: verif/rph_checker.sv
// Histogram checker: watches the config, input and result channels, predicts and compares.
`timescale 1ns / 1ps

module rph_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [rph_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [rph_pkg::PIX_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        operation_i,
  input  logic signed [rph_pkg::PIX_W-1:0]  pixel_i,
  input  logic [rph_pkg::BIN_AW-1:0]        bin_index_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [rph_pkg::CNT_W-1:0]         bin_value_i,
  input  logic [rph_pkg::CNT_W-1:0]         valid_total_i,
  input  logic [rph_pkg::CNT_W-1:0]         invalid_total_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic [rph_pkg::CNT_W-1:0] bin_value;
    logic [rph_pkg::CNT_W-1:0] valid_total;
    logic [rph_pkg::CNT_W-1:0] invalid_total;
  } readout_t;

  // Shadow of the histogram state and its settings
  logic [rph_pkg::CNT_W-1:0]        hist [rph_pkg::BINS];
  logic [rph_pkg::CNT_W-1:0]        valid_cnt;
  logic [rph_pkg::CNT_W-1:0]        invalid_cnt;
  logic signed [rph_pkg::PIX_W-1:0] lo_bound;
  logic signed [rph_pkg::PIX_W-1:0] hi_bound;
  logic [rph_pkg::BC_W-1:0]         bin_cnt;
  logic signed [rph_pkg::PIX_W-1:0] nodata_val;
  logic                             nodata_en;

  readout_t readouts_due [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [rph_pkg::CNT_W-1:0] bump(input logic [rph_pkg::CNT_W-1:0] c);
    return (c == '1) ? c : c + rph_pkg::CNT_W'(1);
  endfunction

  task automatic report_mismatch(input string what, input logic [rph_pkg::CNT_W-1:0] got,
                                 input logic [rph_pkg::CNT_W-1:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // Classify one pixel and count it in the totals and its bin
  task automatic count_pixel(input logic signed [rph_pkg::PIX_W-1:0] px);
    longint span;
    longint bins_eff;
    longint slot;
    if ((nodata_en && px == nodata_val) || px > hi_bound || px < lo_bound) begin
      invalid_cnt = bump(invalid_cnt);
      return;
    end
    valid_cnt = bump(valid_cnt);
    if (hi_bound > lo_bound) begin
      span     = longint'(hi_bound) - longint'(lo_bound);
      bins_eff = (bin_cnt != '0) ? longint'(bin_cnt) : span + 1;
      if (bins_eff > rph_pkg::BINS) bins_eff = rph_pkg::BINS;
    end else begin
      span     = 0;
      bins_eff = 1;
    end
    if (bins_eff <= 1 || span == 0) begin
      slot = 0;
    end else begin
      slot = ((bins_eff - 1) * (longint'(px) - longint'(lo_bound))) / span;
      if (slot >= bins_eff) slot = bins_eff - 1;
    end
    hist[int'(slot)] = bump(hist[int'(slot)]);
  endtask

  // Compare one taken result word with the oldest expected one
  task automatic check_readout();
    readout_t want;
    if (readouts_due.size() == 0) begin
      report_mismatch("result word with none expected, bin_value", bin_value_i, '0);
      return;
    end
    want = readouts_due.pop_front();
    if (bin_value_i !== want.bin_value)
      report_mismatch("bin_value", bin_value_i, want.bin_value);
    if (valid_total_i !== want.valid_total)
      report_mismatch("valid_total", valid_total_i, want.valid_total);
    if (invalid_total_i !== want.invalid_total)
      report_mismatch("invalid_total", invalid_total_i, want.invalid_total);
  endtask

  // Apply one taken input word to the shadow state
  task automatic predict_word(input rph_pkg::op_e op,
                              input logic signed [rph_pkg::PIX_W-1:0] px,
                              input logic [rph_pkg::BIN_AW-1:0] idx);
    readout_t r;
    r = '0;
    case (op)
      rph_pkg::OP_SAMPLE: begin
        count_pixel(px);
      end
      rph_pkg::OP_READ_BIN: begin
        r.bin_value = hist[idx];
        hist[idx]   = '0;
        readouts_due = {readouts_due, r};
      end
      rph_pkg::OP_READ_TOTALS: begin
        r.valid_total   = valid_cnt;
        r.invalid_total = invalid_cnt;
        valid_cnt       = '0;
        invalid_cnt     = '0;
        readouts_due = {readouts_due, r};
      end
      default: ;
    endcase
  endtask

  // Track the channels; results first, then config, then new input words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rph_pkg::BINS; k++) hist[k] = '0;
      valid_cnt   = '0;
      invalid_cnt = '0;
      lo_bound    = 16'sd0;
      hi_bound    = 16'sd255;
      bin_cnt     = '0;
      nodata_val  = 16'sd0;
      nodata_en   = 1'b0;
      readouts_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_readout();
      if (cfg_valid_i && cfg_ready_i) begin
        case (rph_pkg::cfg_idx_e'(cfg_index_i))
          rph_pkg::CFG_RANGE_LOW:     lo_bound   = cfg_data_i;
          rph_pkg::CFG_RANGE_HIGH:    hi_bound   = cfg_data_i;
          rph_pkg::CFG_BIN_COUNT:     bin_cnt    = cfg_data_i[rph_pkg::BC_W-1:0];
          rph_pkg::CFG_NODATA_VALUE:  nodata_val = cfg_data_i;
          rph_pkg::CFG_NODATA_ENABLE: nodata_en  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_word(rph_pkg::op_e'(operation_i), pixel_i, bin_index_i);
      end
      pending_o <= readouts_due.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the histogram testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 24;

  logic                             clk_i;
  logic                             rst_ni = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rph_pkg::CFG_IW-1:0]       cfg_index = '0;
  logic [rph_pkg::PIX_W-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [1:0]                       operation = '0;
  logic signed [rph_pkg::PIX_W-1:0] pixel = '0;
  logic [rph_pkg::BIN_AW-1:0]       bin_index = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [rph_pkg::CNT_W-1:0]        bin_value;
  logic [rph_pkg::CNT_W-1:0]        valid_total;
  logic [rph_pkg::CNT_W-1:0]        invalid_total;

  int fail_count;
  int pending;

  // Stimulus shaping state
  logic                             tx_quiet = 1'b1;
  logic                             rx_quiet = 1'b1;
  logic                             tx_up = 1'b0;
  int                               burst_left = 0;
  int                               stall_left = 0;
  int                               idle_cycles = 0;
  logic signed [rph_pkg::PIX_W-1:0] cur_lo;
  logic signed [rph_pkg::PIX_W-1:0] cur_hi;
  logic signed [rph_pkg::PIX_W-1:0] cur_nodata;
  int                               top_slot;

  ranged_pixel_histogram dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .pixel_i        (pixel),
    .bin_index_i    (bin_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .bin_value_o    (bin_value),
    .valid_total_o  (valid_total),
    .invalid_total_o(invalid_total)
  );

  rph_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .pixel_i        (pixel),
    .bin_index_i    (bin_index),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .bin_value_i    (bin_value),
    .valid_total_i  (valid_total),
    .invalid_total_i(invalid_total),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall result words in runs of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (rx_quiet) begin
      out_stall  <= 1'b0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 7);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // End the run when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one input word, hold it until taken, then maybe open a gap
  task automatic send_word(input rph_pkg::op_e op, input logic signed [rph_pkg::PIX_W-1:0] px,
                           input logic [rph_pkg::BIN_AW-1:0] idx);
    in_valid  <= 1'b1;
    tx_up     = 1'b1;
    operation <= op;
    pixel     <= px;
    bin_index <= idx;
    do @(posedge clk_i); while (in_stall);
    if (!tx_quiet) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        in_valid <= 1'b0;
        tx_up    = 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic drain();
    if (tx_up) begin
      in_valid <= 1'b0;
      tx_up    = 1'b0;
    end
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input rph_pkg::cfg_idx_e idx,
                           input logic [rph_pkg::PIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load all five registers while idle and note the range for stimulus shaping
  task automatic set_config(input logic signed [rph_pkg::PIX_W-1:0] lo,
                            input logic signed [rph_pkg::PIX_W-1:0] hi,
                            input logic [rph_pkg::BC_W-1:0] bc,
                            input logic signed [rph_pkg::PIX_W-1:0] nd, input logic nd_en);
    drain();
    cfg_write(rph_pkg::CFG_RANGE_LOW, lo);
    cfg_write(rph_pkg::CFG_RANGE_HIGH, hi);
    cfg_write(rph_pkg::CFG_BIN_COUNT, rph_pkg::PIX_W'(bc));
    cfg_write(rph_pkg::CFG_NODATA_VALUE, nd);
    cfg_write(rph_pkg::CFG_NODATA_ENABLE, rph_pkg::PIX_W'(nd_en));
    cur_lo     = lo;
    cur_hi     = hi;
    cur_nodata = nd;
    if (hi > lo) begin
      top_slot = (bc != '0) ? int'(bc) : int'(hi) - int'(lo) + 1;
      if (top_slot > rph_pkg::BINS) top_slot = rph_pkg::BINS;
      top_slot = top_slot - 1;
    end else begin
      top_slot = 0;
    end
  endtask

  // Mostly in-range pixels, with bounds, neighbors, no-data and full-range noise
  function automatic logic signed [rph_pkg::PIX_W-1:0] pick_pixel();
    int r;
    int span;
    r = $urandom_range(0, 99);
    if (r < 60 && cur_hi >= cur_lo) begin
      span = int'(cur_hi) - int'(cur_lo);
      return rph_pkg::PIX_W'(int'(cur_lo) + int'($urandom_range(0, span)));
    end
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: return cur_lo;
        1: return cur_hi;
        2: return cur_lo - 16'sd1;
        default: return cur_hi + 16'sd1;
      endcase
    end
    if (r < 80) return cur_nodata;
    return rph_pkg::PIX_W'($urandom);
  endfunction

  task automatic random_words(input int count);
    int r;
    logic [rph_pkg::BIN_AW-1:0] idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_word(rph_pkg::OP_SAMPLE, pick_pixel(), rph_pkg::BIN_AW'($urandom));
      end else if (r < 90) begin
        idx = (r < 85) ? rph_pkg::BIN_AW'($urandom_range(0, top_slot)) :
                         rph_pkg::BIN_AW'($urandom);
        send_word(rph_pkg::OP_READ_BIN, rph_pkg::PIX_W'($urandom), idx);
      end else begin
        send_word(rph_pkg::OP_READ_TOTALS, rph_pkg::PIX_W'($urandom),
                  rph_pkg::BIN_AW'($urandom));
      end
    end
  endtask

  initial begin
    logic signed [rph_pkg::PIX_W-1:0] lo;
    logic signed [rph_pkg::PIX_W-1:0] hi;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bounds, neighbors, no-data, extremes of pixel and bin index
    set_config(-16'sd100, 16'sd100, 9'd10, 16'sd5, 1'b1);
    send_word(rph_pkg::OP_READ_TOTALS, 16'sd0, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, -16'sd32768, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd32767, 8'd255);
    send_word(rph_pkg::OP_SAMPLE, -16'sd100, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd100, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, -16'sd101, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd101, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd5, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd0, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, -16'sd1, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd99, 8'd0);
    send_word(rph_pkg::OP_READ_BIN, 16'sd0, 8'd0);
    send_word(rph_pkg::OP_READ_BIN, 16'sd0, 8'd9);
    send_word(rph_pkg::OP_READ_BIN, -16'sd1, 8'd255);
    send_word(rph_pkg::OP_READ_TOTALS, 16'sd0, 8'd0);

    // Equal bounds: only the one value is binned, into bin zero
    set_config(16'sd7, 16'sd7, 9'd0, 16'sd0, 1'b0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd7, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd8, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd6, 8'd0);
    send_word(rph_pkg::OP_READ_BIN, 16'sd0, 8'd0);
    send_word(rph_pkg::OP_READ_TOTALS, 16'sd0, 8'd0);

    // Inverted range: every sample is invalid
    set_config(16'sd10, -16'sd10, 9'd256, -16'sd1, 1'b0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd0, 8'd0);
    send_word(rph_pkg::OP_SAMPLE, 16'sd10, 8'd0);
    send_word(rph_pkg::OP_READ_TOTALS, 16'sd0, 8'd0);

    // Random phases over extreme and random settings, idling varied per phase
    for (int ph = 0; ph < 10; ph++) begin
      tx_quiet = (ph % 4 == 0) || (ph % 4 == 1);
      rx_quiet <= (ph % 4 == 0) || (ph % 4 == 2);
      case (ph)
        0: set_config(16'sd0, 16'sd255, 9'd0, 16'sd0, 1'b0);
        1: set_config(-16'sd32768, 16'sd32767, 9'd256, -16'sd32768, 1'b1);
        2: set_config(-16'sd32768, 16'sd32767, 9'd0, 16'sd32767, 1'b1);
        3: set_config(-16'sd50, 16'sd50, 9'd1, 16'sd0, 1'b1);
        4: set_config(16'sd100, 16'sd103, 9'd0, 16'sd101, 1'b0);
        5: set_config(16'sd20, 16'sd20, 9'd7, 16'sd20, 1'b1);
        6: set_config(16'sd300, -16'sd300, 9'd2, 16'sd0, 1'b1);
        7: begin
          lo = rph_pkg::PIX_W'($urandom);
          hi = rph_pkg::PIX_W'($urandom);
          set_config(lo, hi, rph_pkg::BC_W'($urandom_range(0, 256)),
                     rph_pkg::PIX_W'($urandom), 1'($urandom));
        end
        default: begin
          lo = rph_pkg::PIX_W'(int'($urandom_range(0, 4000)) - 2000);
          hi = lo + rph_pkg::PIX_W'($urandom_range(1, 3000));
          set_config(lo, hi, rph_pkg::BC_W'($urandom_range(0, 256)),
                     lo + rph_pkg::PIX_W'($urandom_range(0, 50)), 1'($urandom));
        end
      endcase
      random_words(75);
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
